### src/pva_pkg.sv
// Shared constants, types and saturation helpers for the polar vector ALU.
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

    // Fixed-point formats
    localparam int MAG_FRAC_BITS  = 16;
    localparam int UNIT_FRAC_BITS = 14;

    // Square root: 64-bit radicand, 32-bit root, one root bit per stage
    localparam int RAD_W  = 64;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 4;

    // Divider: quotient magnitude never exceeds 2^UNIT_FRAC_BITS
    localparam int QUO_W = UNIT_FRAC_BITS + 1;

    // Op codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_CROSS = 3'd2;
    localparam logic [2:0] OP_DOT   = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;

    // Component selectors
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic signed [63:0] LIM31  = 64'sd2147483647;
    localparam logic signed [63:0] MIN32  = -64'sd2147483648;
    localparam logic signed [63:0] LIM16  = 64'sd32767;
    localparam logic signed [63:0] MIN16  = -64'sd32768;

    // Sideband carried alongside the root and divider pipelines
    typedef struct packed {
        logic              renorm;
        logic              flag;
        logic signed [31:0] mag;
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
    } t_side;

    // Clip to +-(2^31 - 1)
    function automatic logic signed [31:0] sat_sym31(input logic signed [63:0] x);
        if (x > LIM31) begin
            return 32'(LIM31);
        end else if (x < -LIM31) begin
            return 32'(-LIM31);
        end
        return 32'(x);
    endfunction

    function automatic logic ovf_sym31(input logic signed [63:0] x);
        return (x > LIM31) || (x < -LIM31);
    endfunction

    // Clip to the full 32-bit signed range
    function automatic logic signed [31:0] sat_full32(input logic signed [63:0] x);
        if (x > LIM31) begin
            return 32'(LIM31);
        end else if (x < MIN32) begin
            return 32'(MIN32);
        end
        return 32'(x);
    endfunction

    function automatic logic ovf_full32(input logic signed [63:0] x);
        return (x > LIM31) || (x < MIN32);
    endfunction

    // Clip to the 16-bit signed range
    function automatic logic signed [15:0] sat16(input logic signed [63:0] x);
        if (x > LIM16) begin
            return 16'(LIM16);
        end else if (x < MIN16) begin
            return 16'(MIN16);
        end
        return 16'(x);
    endfunction

    function automatic logic ovf16(input logic signed [63:0] x);
        return (x > LIM16) || (x < MIN16);
    endfunction

    // Pick one Cartesian component out of the sideband
    function automatic logic signed [31:0] side_comp(input t_side s, input logic [1:0] j);
        logic signed [31:0] v;
        unique case (j)
            AXIS_X:  v = s.cx;
            AXIS_Y:  v = s.cy;
            AXIS_Z:  v = s.cz;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### src/pva_front.sv
// Front pipeline: components, add/sub, cross, dot, scale and sum of squares.
`timescale 1ns / 1ps
`default_nettype none

module pva_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_a_mag,
    input  logic signed [15:0] i_a_ux,
    input  logic signed [15:0] i_a_uy,
    input  logic signed [15:0] i_a_uz,
    input  logic signed [31:0] i_b_mag,
    input  logic signed [15:0] i_b_ux,
    input  logic signed [15:0] i_b_uy,
    input  logic signed [15:0] i_b_uz,
    output logic               o_valid,
    output logic [63:0]        o_rad,
    output pva_pkg::t_side     o_side
);

    logic signed [15:0] w_au [3];
    logic signed [15:0] w_bu [3];

    assign w_au[0] = i_a_ux;
    assign w_au[1] = i_a_uy;
    assign w_au[2] = i_a_uz;
    assign w_bu[0] = i_b_ux;
    assign w_bu[1] = i_b_uy;
    assign w_bu[2] = i_b_uz;

    // Stage 1: magnitude times direction, and the scale product
    logic [5:0]         r_v;
    logic [2:0]         r_s1_op;
    logic signed [47:0] r_s1_pa [3];
    logic signed [47:0] r_s1_pb [3];
    logic signed [63:0] r_s1_ps;
    logic signed [15:0] r_s1_au [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_op <= i_op;
            r_s1_ps <= i_a_mag * i_b_mag;
            for (int i = 0; i < 3; i++) begin
                r_s1_pa[i] <= i_a_mag * w_au[i];
                r_s1_pb[i] <= i_b_mag * w_bu[i];
                r_s1_au[i] <= w_au[i];
            end
        end
    end

    // Stage 2: shift and clip the components, finish scale
    logic signed [31:0] n_s2_ac [3];
    logic signed [31:0] n_s2_bc [3];
    logic signed [31:0] n_s2_smag;
    logic               n_s2_flag;

    always_comb begin
        logic signed [63:0] v_ta;
        logic signed [63:0] v_tb;
        logic signed [63:0] v_ts;
        logic               v_cov;
        v_cov = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v_ta = 64'(r_s1_pa[i] >>> pva_pkg::UNIT_FRAC_BITS);
            v_tb = 64'(r_s1_pb[i] >>> pva_pkg::UNIT_FRAC_BITS);
            n_s2_ac[i] = pva_pkg::sat_sym31(v_ta);
            n_s2_bc[i] = pva_pkg::sat_sym31(v_tb);
            v_cov = v_cov | pva_pkg::ovf_sym31(v_ta) | pva_pkg::ovf_sym31(v_tb);
        end
        v_ts = r_s1_ps >>> pva_pkg::MAG_FRAC_BITS;
        n_s2_smag = pva_pkg::sat_full32(v_ts);
        n_s2_flag = ((r_s1_op <= pva_pkg::OP_DOT) && v_cov)
                  || ((r_s1_op == pva_pkg::OP_SCALE) && pva_pkg::ovf_full32(v_ts));
    end

    logic [2:0]         r_s2_op;
    logic signed [31:0] r_s2_ac [3];
    logic signed [31:0] r_s2_bc [3];
    logic signed [31:0] r_s2_smag;
    logic               r_s2_flag;
    logic signed [15:0] r_s2_au [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_op   <= r_s1_op;
            r_s2_ac   <= n_s2_ac;
            r_s2_bc   <= n_s2_bc;
            r_s2_smag <= n_s2_smag;
            r_s2_flag <= n_s2_flag;
            r_s2_au   <= r_s1_au;
        end
    end

    // Stage 3: cross and dot products, clipped add/sub
    logic signed [31:0] n_s3_as [3];
    logic               n_s3_asov;

    always_comb begin
        logic signed [63:0] v_s;
        n_s3_asov = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_s2_op == pva_pkg::OP_SUB) begin
                v_s = 64'(r_s2_ac[i]) - 64'(r_s2_bc[i]);
            end else begin
                v_s = 64'(r_s2_ac[i]) + 64'(r_s2_bc[i]);
            end
            n_s3_as[i] = pva_pkg::sat_sym31(v_s);
            n_s3_asov  = n_s3_asov | pva_pkg::ovf_sym31(v_s);
        end
    end

    logic [2:0]         r_s3_op;
    logic signed [63:0] r_s3_cp [6];
    logic signed [63:0] r_s3_dp [3];
    logic signed [31:0] r_s3_as [3];
    logic               r_s3_flag;
    logic signed [31:0] r_s3_smag;
    logic signed [15:0] r_s3_au [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_op    <= r_s2_op;
            r_s3_cp[0] <= r_s2_ac[1] * r_s2_bc[2];
            r_s3_cp[1] <= r_s2_ac[2] * r_s2_bc[1];
            r_s3_cp[2] <= r_s2_ac[2] * r_s2_bc[0];
            r_s3_cp[3] <= r_s2_ac[0] * r_s2_bc[2];
            r_s3_cp[4] <= r_s2_ac[0] * r_s2_bc[1];
            r_s3_cp[5] <= r_s2_ac[1] * r_s2_bc[0];
            for (int i = 0; i < 3; i++) begin
                r_s3_dp[i] <= r_s2_ac[i] * r_s2_bc[i];
            end
            r_s3_as   <= n_s3_as;
            r_s3_flag <= r_s2_flag
                       | (((r_s2_op == pva_pkg::OP_ADD) || (r_s2_op == pva_pkg::OP_SUB))
                          && n_s3_asov);
            r_s3_smag <= r_s2_smag;
            r_s3_au   <= r_s2_au;
        end
    end

    // Stage 4: finish cross and dot, build the sideband
    pva_pkg::t_side n_s4_side;

    always_comb begin
        logic signed [63:0] v_d;
        logic signed [63:0] v_dot;
        logic signed [31:0] v_rc [3];
        logic               v_cov;
        v_cov = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v_d = (r_s3_cp[2*i] - r_s3_cp[2*i+1]) >>> pva_pkg::MAG_FRAC_BITS;
            if (r_s3_op == pva_pkg::OP_CROSS) begin
                v_rc[i] = pva_pkg::sat_sym31(v_d);
                v_cov   = v_cov | pva_pkg::ovf_sym31(v_d);
            end else begin
                v_rc[i] = r_s3_as[i];
            end
        end
        v_dot = (r_s3_dp[0] >>> pva_pkg::MAG_FRAC_BITS)
              + (r_s3_dp[1] >>> pva_pkg::MAG_FRAC_BITS)
              + (r_s3_dp[2] >>> pva_pkg::MAG_FRAC_BITS);

        n_s4_side.renorm = (r_s3_op <= pva_pkg::OP_CROSS);
        n_s4_side.flag   = r_s3_flag | v_cov
                         | ((r_s3_op == pva_pkg::OP_DOT) && pva_pkg::ovf_full32(v_dot));
        n_s4_side.cx = v_rc[0];
        n_s4_side.cy = v_rc[1];
        n_s4_side.cz = v_rc[2];
        if (r_s3_op == pva_pkg::OP_DOT) begin
            n_s4_side.mag = pva_pkg::sat_full32(v_dot);
        end else if (r_s3_op == pva_pkg::OP_SCALE) begin
            n_s4_side.mag = r_s3_smag;
        end else begin
            n_s4_side.mag = '0;
        end
        if (r_s3_op == pva_pkg::OP_SCALE) begin
            n_s4_side.ux = r_s3_au[0];
            n_s4_side.uy = r_s3_au[1];
            n_s4_side.uz = r_s3_au[2];
        end else begin
            n_s4_side.ux = '0;
            n_s4_side.uy = '0;
            n_s4_side.uz = '0;
        end
    end

    pva_pkg::t_side r_s4_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s4_side <= n_s4_side;
        end
    end

    // Stage 5: squares of the clipped components (magnitude below 2^31)
    logic [61:0]    r_s5_sq [3];
    pva_pkg::t_side r_s5_side;

    always_ff @(posedge i_clk) begin
        logic signed [31:0] v_c;
        logic signed [31:0] v_abs;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                v_c   = pva_pkg::side_comp(r_s4_side, 2'(i));
                v_abs = (v_c < 0) ? -v_c : v_c;
                r_s5_sq[i] <= v_abs[30:0] * v_abs[30:0];
            end
            r_s5_side <= r_s4_side;
        end
    end

    // Stage 6: sum of squares
    logic [63:0]    r_s6_rad;
    pva_pkg::t_side r_s6_side;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6_rad  <= 64'(r_s5_sq[0]) + 64'(r_s5_sq[1]) + 64'(r_s5_sq[2]);
            r_s6_side <= r_s5_side;
        end
    end

    assign o_valid = r_v[5];
    assign o_rad   = r_s6_rad;
    assign o_side  = r_s6_side;

endmodule

`default_nettype wire

### src/pva_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module pva_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [pva_pkg::RAD_W-1:0] i_rad,
    input  pva_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [pva_pkg::ROOT_W-1:0] o_root,
    output pva_pkg::t_side            o_side
);

    localparam int NS = pva_pkg::ROOT_W;

    logic [NS-1:0]                 r_v;
    logic [pva_pkg::REM_W-1:0]     r_rem  [NS];
    logic [pva_pkg::ROOT_W-1:0]    r_root [NS];
    logic [pva_pkg::RAD_W-1:0]     r_x    [NS];
    pva_pkg::t_side                r_side [NS];

    logic [pva_pkg::REM_W-1:0]     n_rem  [NS];
    logic [pva_pkg::ROOT_W-1:0]    n_root [NS];
    logic [pva_pkg::RAD_W-1:0]     n_x    [NS];

    // Each stage brings down two radicand bits and tries root bit one
    always_comb begin
        logic [pva_pkg::REM_W-1:0]  v_prem;
        logic [pva_pkg::ROOT_W-1:0] v_proot;
        logic [pva_pkg::RAD_W-1:0]  v_px;
        logic [pva_pkg::REM_W-1:0]  v_cur;
        logic [pva_pkg::REM_W-1:0]  v_trial;
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                v_prem  = '0;
                v_proot = '0;
                v_px    = i_rad;
            end else begin
                v_prem  = r_rem[k-1];
                v_proot = r_root[k-1];
                v_px    = r_x[k-1];
            end
            v_cur   = {v_prem[pva_pkg::REM_W-3:0], v_px[pva_pkg::RAD_W-1 -: 2]};
            v_trial = pva_pkg::REM_W'({v_proot, 2'b01});
            if (v_cur >= v_trial) begin
                n_rem[k]  = v_cur - v_trial;
                n_root[k] = {v_proot[pva_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = v_cur;
                n_root[k] = {v_proot[pva_pkg::ROOT_W-2:0], 1'b0};
            end
            n_x[k] = v_px << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_x    <= n_x;
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_root[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

`default_nettype wire

### src/pva_div.sv
// Three pipelined restoring dividers: |c| * 2^UNIT_FRAC_BITS / n.
`timescale 1ns / 1ps
`default_nettype none

module pva_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [31:0]                         i_n,
    input  pva_pkg::t_side                      i_side,
    output logic                                o_valid,
    output logic [31:0]                         o_n,
    output logic [2:0][pva_pkg::QUO_W-1:0]      o_q,
    output pva_pkg::t_side                      o_side
);

    localparam int NS = pva_pkg::QUO_W;

    logic [NS-1:0]               r_v;
    logic [31:0]                 r_n    [NS];
    logic [31:0]                 r_rem  [NS][3];
    logic [pva_pkg::QUO_W-1:0]   r_q    [NS][3];
    pva_pkg::t_side              r_side [NS];

    logic [31:0]                 n_rem  [NS][3];
    logic [pva_pkg::QUO_W-1:0]   n_q    [NS][3];

    // First stage takes the integer bit (|c| <= n), later stages one fraction bit
    always_comb begin
        logic signed [31:0]        v_c;
        logic [31:0]               v_num;
        logic [32:0]               v_r2;
        for (int j = 0; j < 3; j++) begin
            v_c   = pva_pkg::side_comp(i_side, 2'(j));
            v_num = (v_c < 0) ? 32'(-v_c) : 32'(v_c);
            if (v_num >= i_n) begin
                n_rem[0][j] = v_num - i_n;
                n_q[0][j]   = pva_pkg::QUO_W'(1);
            end else begin
                n_rem[0][j] = v_num;
                n_q[0][j]   = '0;
            end
        end
        for (int k = 1; k < NS; k++) begin
            for (int j = 0; j < 3; j++) begin
                v_r2 = {r_rem[k-1][j], 1'b0};
                if (v_r2 >= {1'b0, r_n[k-1]}) begin
                    n_rem[k][j] = 32'(v_r2 - {1'b0, r_n[k-1]});
                    n_q[k][j]   = {r_q[k-1][j][pva_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[k][j] = 32'(v_r2);
                    n_q[k][j]   = {r_q[k-1][j][pva_pkg::QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_q   <= n_q;
            r_n[0]    <= i_n;
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_n[k]    <= r_n[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_n     = r_n[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_q[0]  = r_q[NS-1][0];
    assign o_q[1]  = r_q[NS-1][1];
    assign o_q[2]  = r_q[NS-1][2];

endmodule

`default_nettype wire

### src/polar_vector3_alu_top.sv
// Top level of the polar vector ALU: front pipeline, root, dividers, output register.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+---------------------------------------------
//  request | i_valid | o_ready | i_op, i_a_mag/ux/uy/uz, i_b_mag/ux/uy/uz
//  result  | o_valid | i_ready | o_res_mag, o_res_ux/uy/uz, o_saturated
//
// One request per cycle while o_ready is high; the path runs through the front pipeline,
// the 32-stage square root, the 15-stage dividers and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// All stages advance together when the output register is empty or being taken,
// so a stall freezes the whole pipe without dropping or repeating anything.
`timescale 1ns / 1ps
`default_nettype none

module polar_vector3_alu_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_a_mag,
    input  logic signed [15:0] i_a_ux,
    input  logic signed [15:0] i_a_uy,
    input  logic signed [15:0] i_a_uz,
    input  logic signed [31:0] i_b_mag,
    input  logic signed [15:0] i_b_ux,
    input  logic signed [15:0] i_b_uy,
    input  logic signed [15:0] i_b_uz,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_res_mag,
    output logic signed [15:0] o_res_ux,
    output logic signed [15:0] o_res_uy,
    output logic signed [15:0] o_res_uz,
    output logic               o_saturated
);

    logic w_en;

    logic                          w_f_valid;
    logic [63:0]                   w_f_rad;
    pva_pkg::t_side                w_f_side;
    logic                          w_s_valid;
    logic [pva_pkg::ROOT_W-1:0]    w_s_root;
    pva_pkg::t_side                w_s_side;
    logic                          w_d_valid;
    logic [31:0]                   w_d_n;
    logic [2:0][pva_pkg::QUO_W-1:0] w_d_q;
    pva_pkg::t_side                w_d_side;

    logic               r_o_valid;
    logic signed [31:0] r_o_mag;
    logic signed [15:0] r_o_u [3];
    logic               r_o_flag;

    // Global advance: output slot free or being drained
    assign w_en    = !r_o_valid || i_ready;
    assign o_ready = w_en;

    pva_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_a_mag (i_a_mag),
        .i_a_ux  (i_a_ux),
        .i_a_uy  (i_a_uy),
        .i_a_uz  (i_a_uz),
        .i_b_mag (i_b_mag),
        .i_b_ux  (i_b_ux),
        .i_b_uy  (i_b_uy),
        .i_b_uz  (i_b_uz),
        .o_valid (w_f_valid),
        .o_rad   (w_f_rad),
        .o_side  (w_f_side)
    );

    pva_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_rad   (w_f_rad),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    pva_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_n     (w_s_root),
        .i_side  (w_s_side),
        .o_valid (w_d_valid),
        .o_n     (w_d_n),
        .o_q     (w_d_q),
        .o_side  (w_d_side)
    );

    // Final select: renormalized result, zero length, or direct dot/scale value
    logic signed [31:0] n_o_mag;
    logic signed [15:0] n_o_u [3];
    logic               n_o_flag;

    always_comb begin
        logic signed [pva_pkg::QUO_W:0] v_qs;
        logic signed [63:0]             v_qw;
        logic                           v_uov;
        v_uov = 1'b0;
        for (int j = 0; j < 3; j++) begin
            v_qs = $signed({1'b0, w_d_q[j]});
            if (pva_pkg::side_comp(w_d_side, 2'(j)) < 0) begin
                v_qs = -v_qs;
            end
            v_qw     = 64'(v_qs);
            n_o_u[j] = pva_pkg::sat16(v_qw);
            v_uov    = v_uov | pva_pkg::ovf16(v_qw);
        end
        if (!w_d_side.renorm) begin
            n_o_mag  = w_d_side.mag;
            n_o_u[0] = w_d_side.ux;
            n_o_u[1] = w_d_side.uy;
            n_o_u[2] = w_d_side.uz;
            n_o_flag = w_d_side.flag;
        end else if (w_d_n == '0) begin
            n_o_mag  = '0;
            n_o_u[0] = '0;
            n_o_u[1] = '0;
            n_o_u[2] = '0;
            n_o_flag = w_d_side.flag;
        end else begin
            n_o_mag  = w_d_n[31] ? 32'(pva_pkg::LIM31) : $signed(w_d_n);
            n_o_flag = w_d_side.flag | w_d_n[31] | v_uov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_mag  <= n_o_mag;
            r_o_u    <= n_o_u;
            r_o_flag <= n_o_flag;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_res_mag   = r_o_mag;
    assign o_res_ux    = r_o_u[0];
    assign o_res_uy    = r_o_u[1];
    assign o_res_uz    = r_o_u[2];
    assign o_saturated = r_o_flag;

endmodule

`default_nettype wire

### tb/polar_vector3_alu_top_tb.sv
// Self-checking testbench for the polar vector ALU top level.
`timescale 1ns / 1ps
`default_nettype none

module polar_vector3_alu_top_tb;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] a_mag;
        logic signed [15:0] a_ux, a_uy, a_uz;
        logic signed [31:0] b_mag;
        logic signed [15:0] b_ux, b_uy, b_uz;
    } t_vec_req;

    typedef struct {
        logic signed [31:0] mag;
        logic signed [15:0] ux, uy, uz;
        logic               sat;
    } t_vec_res;

    localparam longint CLIP31 = 64'sd2147483647;
    localparam int     LATENCY = 60;
    localparam longint CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_op = pva_pkg::OP_ADD;
    logic signed [31:0] i_a_mag = '0;
    logic signed [15:0] i_a_ux = '0, i_a_uy = '0, i_a_uz = '0;
    logic signed [31:0] i_b_mag = '0;
    logic signed [15:0] i_b_ux = '0, i_b_uy = '0, i_b_uz = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_res_mag;
    logic signed [15:0] o_res_ux, o_res_uy, o_res_uz;
    logic               o_saturated;

    t_vec_res expected_results[$];
    int       error_count = 0;
    int       sent_count = 0;
    int       checked_count = 0;
    int       sat_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    longint   cycle_count = 0;

    polar_vector3_alu_top i_dut (.*);

    always #4 i_clk = ~i_clk;

    // Clip helper; sets the saturation flag when it bites
    function automatic longint clip_val(input longint x, input longint lo, input longint hi,
                                        inout logic f);
        if (x < lo) begin
            f = 1'b1;
            return lo;
        end
        if (x > hi) begin
            f = 1'b1;
            return hi;
        end
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned square_abs(input longint c);
        longint unsigned a;
        a = (c < 0) ? longint'(-c) : c;
        return a * a;
    endfunction

    // Back to magnitude plus direction
    function automatic void renormalize(input longint c[3], inout t_vec_res r, inout logic f);
        longint unsigned n;
        longint q;
        longint u[3];
        n = int_sqrt(square_abs(c[0]) + square_abs(c[1]) + square_abs(c[2]));
        if (n == 0) begin
            r.mag = '0; r.ux = '0; r.uy = '0; r.uz = '0;
            return;
        end
        r.mag = 32'(clip_val(longint'(n), 0, CLIP31, f));
        for (int i = 0; i < 3; i++) begin
            q = (c[i] * (64'sd1 <<< pva_pkg::UNIT_FRAC_BITS)) / longint'(n);
            u[i] = clip_val(q, -32768, 32767, f);
        end
        r.ux = 16'(u[0]); r.uy = 16'(u[1]); r.uz = 16'(u[2]);
    endfunction

    // Expected result of one request
    function automatic t_vec_res predict_vector_op(input t_vec_req q);
        t_vec_res r;
        logic f;
        longint am, bm, s;
        longint au[3], bu[3], ac[3], bc[3], rc[3];
        f = 1'b0;
        r.mag = '0; r.ux = '0; r.uy = '0; r.uz = '0;
        am = q.a_mag; bm = q.b_mag;
        au[0] = q.a_ux; au[1] = q.a_uy; au[2] = q.a_uz;
        bu[0] = q.b_ux; bu[1] = q.b_uy; bu[2] = q.b_uz;
        if (q.op <= pva_pkg::OP_DOT) begin
            for (int i = 0; i < 3; i++) begin
                ac[i] = clip_val((am * au[i]) >>> pva_pkg::UNIT_FRAC_BITS,
                                 -CLIP31, CLIP31, f);
                bc[i] = clip_val((bm * bu[i]) >>> pva_pkg::UNIT_FRAC_BITS,
                                 -CLIP31, CLIP31, f);
            end
        end
        case (q.op)
            pva_pkg::OP_ADD, pva_pkg::OP_SUB: begin
                for (int i = 0; i < 3; i++)
                    rc[i] = clip_val((q.op == pva_pkg::OP_ADD) ? ac[i] + bc[i]
                                                               : ac[i] - bc[i],
                                     -CLIP31, CLIP31, f);
                renormalize(rc, r, f);
            end
            pva_pkg::OP_CROSS: begin
                rc[0] = ac[1] * bc[2] - ac[2] * bc[1];
                rc[1] = ac[2] * bc[0] - ac[0] * bc[2];
                rc[2] = ac[0] * bc[1] - ac[1] * bc[0];
                for (int i = 0; i < 3; i++)
                    rc[i] = clip_val(rc[i] >>> pva_pkg::MAG_FRAC_BITS, -CLIP31, CLIP31, f);
                renormalize(rc, r, f);
            end
            pva_pkg::OP_DOT: begin
                s = 0;
                for (int i = 0; i < 3; i++)
                    s += (ac[i] * bc[i]) >>> pva_pkg::MAG_FRAC_BITS;
                r.mag = 32'(clip_val(s, -CLIP31 - 1, CLIP31, f));
            end
            pva_pkg::OP_SCALE: begin
                r.mag = 32'(clip_val((am * bm) >>> pva_pkg::MAG_FRAC_BITS,
                                     -CLIP31 - 1, CLIP31, f));
                r.ux = q.a_ux; r.uy = q.a_uy; r.uz = q.a_uz;
            end
            default: ;
        endcase
        r.sat = f;
        return r;
    endfunction

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("polar_vector3_alu_top test failed");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_vec_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: mag=%0d", o_res_mag);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                checked_count++;
                if (o_res_mag !== e.mag) begin
                    $error("res_mag expected %0d got %0d", e.mag, o_res_mag);
                    error_count++;
                end
                if (o_res_ux !== e.ux) begin
                    $error("res_ux expected %0d got %0d", e.ux, o_res_ux);
                    error_count++;
                end
                if (o_res_uy !== e.uy) begin
                    $error("res_uy expected %0d got %0d", e.uy, o_res_uy);
                    error_count++;
                end
                if (o_res_uz !== e.uz) begin
                    $error("res_uz expected %0d got %0d", e.uz, o_res_uz);
                    error_count++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated expected %0b got %0b", e.sat, o_saturated);
                    error_count++;
                end
            end
        end
    end

    // Drive one request and wait for it to be taken
    task automatic send_request(input t_vec_req q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= q.op;
        i_a_mag <= q.a_mag; i_a_ux <= q.a_ux; i_a_uy <= q.a_uy; i_a_uz <= q.a_uz;
        i_b_mag <= q.b_mag; i_b_ux <= q.b_ux; i_b_uy <= q.b_uy; i_b_uz <= q.b_uz;
        do @(posedge i_clk); while (!o_ready);
        expected_results.push_back(predict_vector_op(q));
        if (expected_results[$].sat) sat_count++;
        sent_count++;
    endtask

    function automatic t_vec_req make_req(input logic [2:0] op,
            input logic signed [31:0] am, input logic signed [15:0] ax, ay, az,
            input logic signed [31:0] bm, input logic signed [15:0] bx, by, bz);
        t_vec_req q;
        q.op = op;
        q.a_mag = am; q.a_ux = ax; q.a_uy = ay; q.a_uz = az;
        q.b_mag = bm; q.b_ux = bx; q.b_uy = by; q.b_uz = bz;
        return q;
    endfunction

    // Every op on simple unit vectors
    task automatic test_each_op();
        for (int op = 0; op < 8; op++)
            send_request(make_req(3'(op), 32'sh0003_0000, 16384, 0, 0,
                                  32'sh0002_0000, 0, 16384, 0));
    endtask

    // Field extremes, clipping paths
    task automatic test_extremes();
        send_request(make_req(pva_pkg::OP_ADD, 32'h7fffffff, 32767, 32767, 32767,
                              32'h7fffffff, 32767, 32767, 32767));
        send_request(make_req(pva_pkg::OP_SUB, 32'h80000000, -32768, -32768, -32768,
                              32'h7fffffff, 32767, 32767, 32767));
        send_request(make_req(pva_pkg::OP_CROSS, 32'h7fffffff, 32767, -32768, 32767,
                              32'h80000000, -32768, 32767, 32767));
        send_request(make_req(pva_pkg::OP_DOT, 32'h80000000, -32768, -32768, -32768,
                              32'h80000000, -32768, -32768, -32768));
        send_request(make_req(pva_pkg::OP_SCALE, 32'h7fffffff, 32767, -32768, 1,
                              32'h7fffffff, 0, 0, 0));
        send_request(make_req(pva_pkg::OP_SCALE, 32'h80000000, -1, 0, 1,
                              32'h7fffffff, -1, -1, -1));
        send_request(make_req(pva_pkg::OP_ADD, 32'h00000001, 1, -1, 1,
                              32'hffffffff, -1, 1, -1));
    endtask

    // Zero length, negative magnitudes, unnormalized directions, dot direction, an unused op code
    task automatic test_special_cases();
        send_request(make_req(pva_pkg::OP_SUB, 32'sh0005_0000, 9459, 9459, 9459,
                              32'sh0005_0000, 9459, 9459, 9459));
        send_request(make_req(pva_pkg::OP_ADD, 32'sh0005_0000, 0, 16384, 0,
                              -32'sh0005_0000, 0, 16384, 0));
        send_request(make_req(pva_pkg::OP_CROSS, 32'sh0004_0000, 16384, 0, 0,
                              32'sh0007_0000, -16384, 0, 0));
        send_request(make_req(pva_pkg::OP_ADD, 32'sh0000_0000, 16384, 0, 0,
                              32'sh0000_0000, 0, 0, 16384));
        send_request(make_req(pva_pkg::OP_ADD, -32'sh0003_0000, 0, 0, 16384,
                              32'sh0001_0000, 16384, 0, 0));
        send_request(make_req(pva_pkg::OP_ADD, 32'sh0001_0000, 1000, 2000, -3000,
                              32'sh0002_0000, 5, -7, 20000));
        send_request(make_req(pva_pkg::OP_DOT, 32'sh0002_8000, 11585, 11585, 0,
                              -32'sh0001_0000, 0, 11585, 11585));
        send_request(make_req(3'd6, 32'h7fffffff, 32767, 32767, 32767,
                              32'h7fffffff, 32767, 32767, 32767));
    endtask

    function automatic logic signed [15:0] rand_unit_comp();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return 16'sd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_mag();
        case ($urandom_range(5))
            0: return 32'($urandom);
            1: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($urandom_range(255));
            default: return 32'($signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000);
        endcase
    endfunction

    // Random requests under one idle/stall setting
    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        t_vec_req q;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            q.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            q.a_mag = rand_mag();
            q.a_ux = rand_unit_comp(); q.a_uy = rand_unit_comp(); q.a_uz = rand_unit_comp();
            q.b_mag = ($urandom_range(9) == 0) ? q.a_mag : rand_mag();
            q.b_ux = rand_unit_comp(); q.b_uy = rand_unit_comp(); q.b_uz = rand_unit_comp();
            send_request(q);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_each_op();
        test_extremes();
        test_special_cases();
        test_random(170, 0, 0);
        test_random(160, 72, 0);
        test_random(160, 0, 72);
        test_random(160, 34, 34);
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        $display("sent %0d requests over all ops and idle/stall phases", sent_count);
        $display("checked %0d results, %0d of them saturated", checked_count, sat_count);
        if (error_count == 0) begin
            $display("polar_vector3_alu_top test passed");
        end else begin
            $display("polar_vector3_alu_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
